// ===== design/audio_minmax_peak_pyramid_unit_macros.svh =====
// Assertion macros used by the cascade design file (ampp_cascade.sv).
`ifndef AUDIO_MINMAX_PEAK_PYRAMID_UNIT_MACROS_SVH
`define AUDIO_MINMAX_PEAK_PYRAMID_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define AMPP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ampp: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define AMPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ampp: next-cycle check failed");

`endif

// ===== design/ampp_pkg.sv =====
package ampp_pkg;

    localparam int SAMPLES_PER_BIN = 256;
    localparam int LEVELS          = 16;
    localparam int MAX_CHANNELS    = 8;
    localparam int RESULT_CAP      = 32;

    localparam int SAMPLE_W  = 16;
    localparam int LVL_W     = 4;
    localparam int BIN_IDX_W = 32;
    localparam int CH_W      = 4;
    localparam int CNT_W     = $clog2(SAMPLES_PER_BIN) + 1;
    localparam int NCAP_W    = $clog2(RESULT_CAP) + 1;

    // Configuration register index (paddr[2])
    localparam logic REG_CHANNEL_COUNT = 1'b0;

    typedef enum logic [0:0] {
        OP_FRAME = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAME,
        ST_FLUSH,
        ST_PUSH,
        ST_WALK,
        ST_END
    } state_t;

    // Where the sequencer resumes once a cascade is finished
    typedef enum logic [1:0] {
        RET_END,
        RET_WALK0,
        RET_WALK_NEXT
    } ret_t;

    typedef struct packed {
        logic        [SAMPLE_W:0]   mag;
        logic signed [SAMPLE_W-1:0] value;
    } lane_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mx;
        logic signed [SAMPLE_W-1:0] mn;
        logic        [BIN_IDX_W-1:0] idx;
        logic        [LVL_W-1:0]    lvl;
    } result_t;

endpackage

// ===== design/ampp_lane.sv =====
module ampp_lane
    import ampp_pkg::*;
(
    input  logic                       en,
    input  logic signed [SAMPLE_W-1:0] sample,
    output lane_t                      lane
);

    logic [SAMPLE_W:0] sample_ext;

    // Widen by one bit so that the most negative sample has a true magnitude
    assign sample_ext = {sample[SAMPLE_W-1], sample};

    // Drop a channel beyond the configured count to magnitude zero
    always_comb begin
        lane.value = en ? sample : '0;
        if (!en) begin
            lane.mag = '0;
        end else if (sample[SAMPLE_W-1]) begin
            lane.mag = (SAMPLE_W+1)'(~sample_ext + 1'b1);
        end else begin
            lane.mag = sample_ext;
        end
    end

endmodule

// ===== design/ampp_merge.sv =====
module ampp_merge
    import ampp_pkg::*;
(
    input  lane_t [MAX_CHANNELS-1:0]    lanes,
    output logic signed [SAMPLE_W-1:0]  pick
);

    lane_t best;

    // Scan the lanes in channel order; only a strictly larger magnitude replaces
    always_comb begin
        best = lanes[0];
        for (int c = 1; c < MAX_CHANNELS; c++) begin
            if (lanes[c].mag > best.mag) begin
                best = lanes[c];
            end
        end
        pick = best.value;
    end

endmodule

// ===== design/ampp_cascade.sv =====
module ampp_cascade
    import ampp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  op_t                        in_op,
    input  logic signed [SAMPLE_W-1:0] in_pick,
    output logic                       out_valid,
    input  logic                       out_ready,
    output result_t                    out_result,
    output logic                       out_last
);

    `include "audio_minmax_peak_pyramid_unit_macros.svh"

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    ret_t   ret_reg, ret_next;

    logic signed [SAMPLE_W-1:0] pick_reg, pick_next;
    logic signed [SAMPLE_W-1:0] pend_min_reg, pend_min_next;
    logic signed [SAMPLE_W-1:0] pend_max_reg, pend_max_next;
    logic        [CNT_W-1:0]    pend_cnt_reg, pend_cnt_next;

    logic signed [SAMPLE_W-1:0] held_min_reg [LEVELS];
    logic signed [SAMPLE_W-1:0] held_min_next [LEVELS];
    logic signed [SAMPLE_W-1:0] held_max_reg [LEVELS];
    logic signed [SAMPLE_W-1:0] held_max_next [LEVELS];
    logic        [LEVELS-1:0]   held_vld_reg, held_vld_next;
    logic        [BIN_IDX_W-1:0] bin_cnt_reg [LEVELS];
    logic        [BIN_IDX_W-1:0] bin_cnt_next [LEVELS];

    logic        [LVL_W-1:0]    lvl_reg, lvl_next;
    logic        [LVL_W-1:0]    walk_lv_reg, walk_lv_next;
    logic signed [SAMPLE_W-1:0] cur_min_reg, cur_min_next;
    logic signed [SAMPLE_W-1:0] cur_max_reg, cur_max_next;
    logic        [NCAP_W-1:0]   n_reg, n_next;

    logic    hold_vld_reg, hold_vld_next;
    result_t hold_reg, hold_next;
    logic    out_vld_reg, out_vld_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;

    logic                       out_free;
    logic                       can_emit;
    logic                       push_cap;
    logic                       at_top;
    logic                       push_done;
    logic                       emit;
    logic                       walk_stop;
    logic                       end_done;
    logic                       frame_bin;
    logic        [CNT_W-1:0]    pend_inc;
    logic        [BIN_IDX_W-1:0] rd_cnt;
    logic                       rd_held;
    logic signed [SAMPLE_W-1:0] rd_min;
    logic signed [SAMPLE_W-1:0] rd_max;
    logic signed [SAMPLE_W-1:0] fold_min;
    logic signed [SAMPLE_W-1:0] fold_max;

    // Level store read at the current level
    assign rd_cnt  = bin_cnt_reg[lvl_reg];
    assign rd_held = held_vld_reg[lvl_reg];
    assign rd_min  = held_min_reg[lvl_reg];
    assign rd_max  = held_max_reg[lvl_reg];

    // Pending bin with this frame's pick folded in
    assign fold_min = (pick_reg < pend_min_reg) ? pick_reg : pend_min_reg;
    assign fold_max = (pick_reg > pend_max_reg) ? pick_reg : pend_max_reg;
    assign pend_inc = pend_cnt_reg + CNT_W'(1);

    assign out_free  = !out_vld_reg || out_ready;
    assign can_emit  = !hold_vld_reg || out_free;
    assign push_cap  = (n_reg == NCAP_W'(RESULT_CAP));
    assign at_top    = (lvl_reg == LVL_W'(LEVELS - 1));
    assign emit      = (state_reg == ST_PUSH) && !push_cap && can_emit;
    assign push_done = (state_reg == ST_PUSH)
                     && (push_cap || (can_emit && (at_top || !rd_held)));
    assign walk_stop = at_top || (rd_cnt <= BIN_IDX_W'(1));
    assign end_done  = (state_reg == ST_END) && (!hold_vld_reg || out_free);
    assign frame_bin = (pend_cnt_reg != '0) && (pend_inc == CNT_W'(SAMPLES_PER_BIN));

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_vld_reg;
    assign out_result = out_reg;
    assign out_last   = out_last_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (in_op == OP_FLUSH) ? ST_FLUSH : ST_FRAME;
                end
            end
            ST_FRAME: begin
                state_next = frame_bin ? ST_PUSH : ST_IDLE;
            end
            ST_FLUSH: begin
                state_next = (pend_cnt_reg != '0) ? ST_PUSH : ST_WALK;
            end
            ST_PUSH: begin
                if (push_done) begin
                    state_next = (ret_reg == RET_END) ? ST_END : ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_stop) begin
                    state_next = ST_END;
                end else if (rd_held) begin
                    state_next = ST_PUSH;
                end
            end
            ST_END: begin
                if (end_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and level store updates
    always_comb begin
        op_next       = op_reg;
        ret_next      = ret_reg;
        pick_next     = pick_reg;
        pend_min_next = pend_min_reg;
        pend_max_next = pend_max_reg;
        pend_cnt_next = pend_cnt_reg;
        held_min_next = held_min_reg;
        held_max_next = held_max_reg;
        held_vld_next = held_vld_reg;
        bin_cnt_next  = bin_cnt_reg;
        lvl_next      = lvl_reg;
        walk_lv_next  = walk_lv_reg;
        cur_min_next  = cur_min_reg;
        cur_max_next  = cur_max_reg;
        n_next        = n_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next   = in_op;
                    pick_next = in_pick;
                    n_next    = '0;
                end
            end
            ST_FRAME: begin
                if (pend_cnt_reg == '0) begin
                    pend_min_next = pick_reg;
                    pend_max_next = pick_reg;
                    pend_cnt_next = CNT_W'(1);
                end else if (frame_bin) begin
                    pend_min_next = '0;
                    pend_max_next = '0;
                    pend_cnt_next = '0;
                    cur_min_next  = fold_min;
                    cur_max_next  = fold_max;
                    lvl_next      = '0;
                    ret_next      = RET_END;
                end else begin
                    pend_min_next = fold_min;
                    pend_max_next = fold_max;
                    pend_cnt_next = pend_inc;
                end
            end
            ST_FLUSH: begin
                lvl_next     = '0;
                cur_min_next = pend_min_reg;
                cur_max_next = pend_max_reg;
                ret_next     = RET_WALK0;
            end
            ST_PUSH: begin
                if (emit) begin
                    // Emit the bin; the previous one in the hold stage moves on
                    if (hold_vld_reg) begin
                        out_next      = hold_reg;
                        out_last_next = 1'b0;
                        out_vld_next  = 1'b1;
                    end
                    hold_vld_next  = 1'b1;
                    hold_next.lvl  = lvl_reg;
                    hold_next.idx  = rd_cnt;
                    hold_next.mn   = cur_min_reg;
                    hold_next.mx   = cur_max_reg;
                    n_next         = n_reg + NCAP_W'(1);
                    if (rd_cnt != '1) begin
                        bin_cnt_next[lvl_reg] = rd_cnt + BIN_IDX_W'(1);
                    end
                    // Pair with the held bin, or park this one
                    if (!at_top) begin
                        if (rd_held) begin
                            if (rd_min < cur_min_reg) begin
                                cur_min_next = rd_min;
                            end
                            if (rd_max > cur_max_reg) begin
                                cur_max_next = rd_max;
                            end
                            held_vld_next[lvl_reg] = 1'b0;
                            lvl_next = lvl_reg + LVL_W'(1);
                        end else begin
                            held_min_next[lvl_reg] = cur_min_reg;
                            held_max_next[lvl_reg] = cur_max_reg;
                            held_vld_next[lvl_reg] = 1'b1;
                        end
                    end
                end
                if (push_done) begin
                    if (ret_reg == RET_WALK0) begin
                        lvl_next = '0;
                    end else if (ret_reg == RET_WALK_NEXT) begin
                        lvl_next = walk_lv_reg + LVL_W'(1);
                    end
                end
            end
            ST_WALK: begin
                if (!walk_stop) begin
                    if (rd_held) begin
                        // Promote the unpaired bin one level up
                        held_vld_next[lvl_reg] = 1'b0;
                        walk_lv_next = lvl_reg;
                        cur_min_next = rd_min;
                        cur_max_next = rd_max;
                        ret_next     = RET_WALK_NEXT;
                    end
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            ST_END: begin
                if (end_done) begin
                    // Release the final bin with its last flag
                    if (hold_vld_reg) begin
                        out_next      = hold_reg;
                        out_last_next = 1'b1;
                        out_vld_next  = 1'b1;
                    end
                    hold_vld_next = 1'b0;
                    if (op_reg == OP_FLUSH) begin
                        pend_cnt_next = '0;
                        pend_min_next = '0;
                        pend_max_next = '0;
                        held_vld_next = '0;
                        for (int l = 0; l < LEVELS; l++) begin
                            bin_cnt_next[l] = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_cnt_reg <= '0;
            held_vld_reg <= '0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            n_reg        <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                bin_cnt_reg[l] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            pend_cnt_reg <= pend_cnt_next;
            held_vld_reg <= held_vld_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
            n_reg        <= n_next;
            bin_cnt_reg  <= bin_cnt_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        ret_reg      <= ret_next;
        pick_reg     <= pick_next;
        pend_min_reg <= pend_min_next;
        pend_max_reg <= pend_max_next;
        held_min_reg <= held_min_next;
        held_max_reg <= held_max_next;
        lvl_reg      <= lvl_next;
        walk_lv_reg  <= walk_lv_next;
        cur_min_reg  <= cur_min_next;
        cur_max_reg  <= cur_max_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    `AMPP_ASSERT_IMPLY(a_ready_hold_empty, in_ready, !hold_vld_reg)
    `AMPP_ASSERT_IMPLY(a_result_cap, state_reg != ST_IDLE, n_reg <= NCAP_W'(RESULT_CAP))
    `AMPP_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != ST_IDLE)
    `AMPP_ASSERT_NEXT(a_hold_from_emit, !hold_vld_reg && !emit, !hold_vld_reg)

endmodule

// ===== design/audio_minmax_peak_pyramid_unit.sv =====
// Channel   Direction  Contents
// s_*       in         frame of channel samples (tdata) or flush (tuser)
// m_*       out        one min/max bin per item, tlast on the final one
// APB       in/out     register 0: channel_count
//
// An input item is taken only while the sequencer is idle.
// A frame that closes no bin passes through the frame state only; one that
// closes a bin then runs the cascade, one level per cycle unless m_ stalls.
// A flush pushes any pending bin, then walks the levels, promoting unpaired bins.
// A stalled m_ channel holds the sequencer once its hold stage is full.
// aresetn is synchronous, active low; channel_count returns to 1.
module audio_minmax_peak_pyramid_unit
    import ampp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // chan0_sample .. chan7_sample, 16 bits each
    input  logic [0:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // level_index, bin_index, bin_min, bin_max, zero pad
    output logic         m_tlast,   // last
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [CH_W-1:0]                ch_cnt_reg, ch_cnt_next;
    logic [CH_W-1:0]                ch_eff;
    lane_t [MAX_CHANNELS-1:0]       lanes;
    logic signed [SAMPLE_W-1:0]     pick;
    result_t                        result;

    // Configuration register
    assign pready = 1'b1;

    always_comb begin
        ch_cnt_next = ch_cnt_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_CHANNEL_COUNT)) begin
            ch_cnt_next = pwdata[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_cnt_reg <= CH_W'(1);
        end else begin
            ch_cnt_reg <= ch_cnt_next;
        end
    end

    assign prdata = (paddr[2] == REG_CHANNEL_COUNT) ? {{(32-CH_W){1'b0}}, ch_cnt_reg} : '0;

    // Clamp the channel count into one to MAX_CHANNELS
    always_comb begin
        if (ch_cnt_reg == '0) begin
            ch_eff = CH_W'(1);
        end else if (ch_cnt_reg > CH_W'(MAX_CHANNELS)) begin
            ch_eff = CH_W'(MAX_CHANNELS);
        end else begin
            ch_eff = ch_cnt_reg;
        end
    end

    // One magnitude lane per channel
    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
        ampp_lane u_lane (
            .en     (CH_W'(c) < ch_eff),
            .sample (s_tdata[c*SAMPLE_W +: SAMPLE_W]),
            .lane   (lanes[c])
        );
    end

    ampp_merge u_merge (
        .lanes (lanes),
        .pick  (pick)
    );

    ampp_cascade u_cascade (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (op_t'(s_tuser[0])),
        .in_pick    (pick),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .out_last   (m_tlast)
    );

    // Pack the result item, first field lowest
    assign m_tdata = {4'b0000, result.mx, result.mn, result.idx, result.lvl};

endmodule
